// ----- design/ctm_pkg.sv -----
package ctm_pkg;

	localparam int NUM_PC     = 12;
	localparam int TYPE_COUNT = 11;
	localparam int NOTE_W     = 4;
	localparam int TYPE_W     = 4;
	localparam int SIZE_W     = 3;

	localparam logic [NUM_PC-1:0] BASE_MASK [TYPE_COUNT] = '{
		12'h095, 12'h891, 12'h489, 12'h491, 12'h889,
		12'h049, 12'h0A1, 12'h085, 12'h091, 12'h089,
		12'h081
	};

	localparam logic [SIZE_W-1:0] TYPE_SIZE [TYPE_COUNT] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd2
	};

	localparam logic [NOTE_W-1:0] PC_LOW  = 4'd1;
	localparam logic [NOTE_W-1:0] PC_HIGH = 4'd12;

	// A gathered chord, handed from the accumulator to the matcher.
	typedef struct packed {
		logic [NUM_PC-1:0] pitch_set;
		logic [NOTE_W-1:0] first_pitch;
		logic              bad_note_seen;
	} chord_t;

	typedef struct packed {
		logic [NOTE_W-1:0] root_pitch;
		logic [TYPE_W-1:0] chord_type;
		logic              found;
	} result_t;

	// Rotate a pitch mask toward higher pitch classes by r steps.
	function automatic logic [NUM_PC-1:0] rotate12(input logic [NUM_PC-1:0] m,
	                                               input logic [NOTE_W-1:0] r);
		logic [2*NUM_PC-1:0] w;
		w = {m, m} << r;
		return w[2*NUM_PC-1:NUM_PC];
	endfunction

endpackage

// ----- design/ctm_accum.sv -----
module ctm_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [3:0]           note,
	input  logic                 last_note,
	input  logic                 s1_ready,
	output logic                 s1_valid,
	output ctm_pkg::chord_t      chord_s1
);
	import ctm_pkg::*;

	logic [NUM_PC-1:0] pitch_set_q;
	logic [NOTE_W-1:0] first_pitch_q;
	logic              bad_q;
	logic              awaiting_q;

	logic [NUM_PC-1:0] set_nx;
	logic [NOTE_W-1:0] first_nx;
	logic              bad_nx;
	logic              note_ok;

	always_comb begin
		note_ok  = (note >= PC_LOW) && (note <= PC_HIGH);
		set_nx   = awaiting_q ? '0 : pitch_set_q;
		bad_nx   = awaiting_q ? 1'b0 : bad_q;
		first_nx = awaiting_q ? note : first_pitch_q;
		if (note_ok) begin
			set_nx = set_nx | (NUM_PC'(1) << (note - PC_LOW));
		end else begin
			bad_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_set_q   <= '0;
			first_pitch_q <= '0;
			bad_q         <= 1'b0;
			awaiting_q    <= 1'b1;
		end else if (accept) begin
			if (last_note) begin
				pitch_set_q   <= '0;
				first_pitch_q <= '0;
				bad_q         <= 1'b0;
				awaiting_q    <= 1'b1;
			end else begin
				pitch_set_q   <= set_nx;
				first_pitch_q <= first_nx;
				bad_q         <= bad_nx;
				awaiting_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_ready) begin
			s1_valid <= accept && last_note;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_note) begin
			chord_s1.pitch_set     <= set_nx;
			chord_s1.first_pitch   <= first_nx;
			chord_s1.bad_note_seen <= bad_nx;
		end
	end

endmodule

// ----- design/ctm_match.sv -----
module ctm_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	input  ctm_pkg::chord_t      chord_s1,
	input  logic                 out_ready,
	output logic                 res_valid_s2,
	output ctm_pkg::result_t     res_s2
);
	import ctm_pkg::*;

	logic [NUM_PC-1:0]    hit [TYPE_COUNT];
	logic [TYPE_COUNT-1:0] in_class;
	logic                 any2, any3, any_hit;
	logic [SIZE_W-1:0]    win_size;
	logic [NOTE_W-1:0]    root_idx;
	logic                 root_ok;
	logic                 got_first, got_root;
	logic [TYPE_W-1:0]    first_t, root_t;
	logic [NOTE_W-1:0]    first_r;
	result_t              res_nx;

	always_comb begin
		for (int t = 0; t < TYPE_COUNT; t++) begin
			for (int r = 0; r < NUM_PC; r++) begin
				hit[t][r] = !chord_s1.bad_note_seen &&
				            ((chord_s1.pitch_set &
				              ~rotate12(BASE_MASK[t], NOTE_W'(r))) == '0);
			end
		end

		any2    = 1'b0;
		any3    = 1'b0;
		any_hit = 1'b0;
		for (int t = 0; t < TYPE_COUNT; t++) begin
			if (TYPE_SIZE[t] == 3'd2) any2 = any2 | (|hit[t]);
			if (TYPE_SIZE[t] == 3'd3) any3 = any3 | (|hit[t]);
			any_hit = any_hit | (|hit[t]);
		end
		win_size = any2 ? 3'd2 : (any3 ? 3'd3 : 3'd4);
		for (int t = 0; t < TYPE_COUNT; t++) begin
			in_class[t] = (TYPE_SIZE[t] == win_size);
		end

		// Root-position candidate: the last type of the winning size whose
		// rotation starting at the first note matches.
		root_ok  = (chord_s1.first_pitch >= PC_LOW) && (chord_s1.first_pitch <= PC_HIGH);
		root_idx = chord_s1.first_pitch - PC_LOW;
		got_root = 1'b0;
		root_t   = '0;
		for (int t = 0; t < TYPE_COUNT; t++) begin
			if (root_ok && in_class[t] && hit[t][root_idx]) begin
				got_root = 1'b1;
				root_t   = TYPE_W'(t);
			end
		end

		// Fallback: the first match of the winning size in type, root order.
		got_first = 1'b0;
		first_t   = '0;
		first_r   = '0;
		for (int t = 0; t < TYPE_COUNT; t++) begin
			for (int r = 0; r < NUM_PC; r++) begin
				if (!got_first && in_class[t] && hit[t][r]) begin
					got_first = 1'b1;
					first_t   = TYPE_W'(t);
					first_r   = NOTE_W'(r);
				end
			end
		end

		res_nx.found = any_hit;
		if (!any_hit) begin
			res_nx.chord_type = '0;
			res_nx.root_pitch = '0;
		end else if (got_root) begin
			res_nx.chord_type = root_t;
			res_nx.root_pitch = chord_s1.first_pitch;
		end else begin
			res_nx.chord_type = first_t;
			res_nx.root_pitch = first_r + PC_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_ready) begin
			res_valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s1_valid) begin
			res_s2 <= res_nx;
		end
	end

endmodule

// ----- design/chord_template_matcher_top.sv -----
// Chord template matcher.
// Notes enter on the slave stream, one pitch class per transfer in s_tdata,
// with s_tlast high on the final note of a chord. The notes of a chord are
// gathered into a pitch set; on the last note the set is tested against the
// eleven chord types in all twelve rotations, and one result transfer leaves
// on the master stream: found, chord type and root pitch class. Notes that
// are not last produce no transfer. A note outside 1 to 12 makes the whole
// chord report no match, with type and root zero.
// Throughput is one note per cycle while s_tready is high. After the last
// note, a chord passes two registers: the chord register, then the result
// register where the template tests and winner selection sit.
// When the receiver stalls, the result holds in its register and the chord
// register still takes one more chord; after that s_tready drops until
// m_tready returns. Reset clears the partial chord and both valid flags.
module chord_template_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] note, [7:4] zero
	input  logic        s_tlast,   // last_note
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] found, [4:1] chord_type, [8:5] root_pitch, rest zero
);
	import ctm_pkg::*;

	logic    accept;
	logic    s1_valid, s1_ready;
	logic    out_ready;
	chord_t  chord_s1;
	result_t res_s2;

	// The result register frees up when empty or taken this cycle; the chord
	// register frees up when empty or moving into the result register.
	assign out_ready = !m_tvalid || m_tready;
	assign s1_ready  = !s1_valid || out_ready;
	assign s_tready  = s1_ready;
	assign accept    = s_tvalid && s_tready;

	ctm_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.note      (s_tdata[3:0]),
		.last_note (s_tlast),
		.s1_ready  (s1_ready),
		.s1_valid  (s1_valid),
		.chord_s1  (chord_s1)
	);

	ctm_match u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.chord_s1     (chord_s1),
		.out_ready    (out_ready),
		.res_valid_s2 (m_tvalid),
		.res_s2       (res_s2)
	);

	assign m_tdata = {7'd0, res_s2.root_pitch, res_s2.chord_type, res_s2.found};

endmodule

// ----- design/ctm_checker.sv -----
module ctm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No match reports type and root as zero.
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
		else $error("no-match result carries type or root");

	// A match names a real type and a root in 1 to 12.
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[4:1] <= 4'd10 &&
		m_tdata[8:5] >= 4'd1 && m_tdata[8:5] <= 4'd12)
		else $error("match result out of range");

	// A newly valid result must come from a last-note transfer that passed the
	// chord register and the result register, or follow an earlier result.
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2) || $past(m_tvalid, 2))
		else $error("result without a last note");

	// Pad bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0)
		else $error("result pad bits set");

endmodule

bind chord_template_matcher_top ctm_checker u_ctm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
